// File: design/dls_pkg.sv
// Shared types, codes and reset values for the door lock sequencer.
// No dependencies; imported by dls_step and door_lock_sequencer_core.
package dls_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;

    // Door machine, one-hot
    typedef enum logic [3:0] {
        PH_LOCKED   = 4'b0001,
        PH_PREPARED = 4'b0010,
        PH_OPENED   = 4'b0100,
        PH_TIMEDOUT = 4'b1000
    } phase_t;

    // Encoded phase as seen on the result stream
    localparam logic [1:0] PC_LOCKED   = 2'd0;
    localparam logic [1:0] PC_PREPARED = 2'd1;
    localparam logic [1:0] PC_OPENED   = 2'd2;
    localparam logic [1:0] PC_TIMEDOUT = 2'd3;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_OPEN  = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] RELEASE_RST    = 16'd3000;
    localparam logic [CFG_W-1:0] OPEN_LIMIT_RST = 16'd30000;

    typedef struct packed {
        phase_t phase;
        logic   magnet;
        logic   level;
    } ctl_t;

    typedef struct packed {
        logic       alert;
        logic [1:0] door_event;
        logic [1:0] door_phase;
        logic       magnet_drive;
    } res_t;

    function automatic logic [1:0] phase_code(phase_t ph);
        logic [1:0] code;
        code = PC_LOCKED;
        unique case (ph)
            PH_LOCKED:   code = PC_LOCKED;
            PH_PREPARED: code = PC_PREPARED;
            PH_OPENED:   code = PC_OPENED;
            PH_TIMEDOUT: code = PC_TIMEDOUT;
            default:     code = PC_LOCKED;
        endcase
        return code;
    endfunction

endpackage

// File: design/door_lock_sequencer_core.sv
// Top level of the door lock sequencer: stream ports, config registers,
// state registers and result register. Depends on dls_pkg and dls_step.
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle; the single output register is reloaded
//   in the cycle it is taken, so input stalls only while a result waits.
// Reset (rst_n low, async): phase locked, magnet energized, level closed,
//   timers zero, config at defaults, output empty.
module door_lock_sequencer_core
    import dls_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] sensor_level, [1] open_request, [7:2] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] magnet_drive, [2:1] door_phase,
                                            // [4:3] door_event, [5] alert, [7:6] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]       debounce_ticks_reg;
    logic [CFG_W-1:0]       release_ticks_reg;
    logic [CFG_W-1:0]       open_limit_ticks_reg;
    ctl_t                   ctl_reg;
    ctl_t                   ctl_next;
    logic [TIMER_WIDTH-1:0] dbe_reg;
    logic [TIMER_WIDTH-1:0] dbe_next;
    logic [TIMER_WIDTH-1:0] rel_reg;
    logic [TIMER_WIDTH-1:0] rel_next;
    logic [TIMER_WIDTH-1:0] opn_reg;
    logic [TIMER_WIDTH-1:0] opn_next;
    res_t                   res_next;
    res_t                   res_reg;
    logic                   out_valid_reg;
    logic                   s_fire;
    logic                   m_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_RST;
            release_ticks_reg    <= RELEASE_RST;
            open_limit_ticks_reg <= OPEN_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   debounce_ticks_reg   <= cfg_data;
                CFG_RELEASE:    release_ticks_reg    <= cfg_data;
                CFG_OPEN_LIMIT: open_limit_ticks_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    dls_step #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_step (
        .ctl              (ctl_reg),
        .dbe              (dbe_reg),
        .rel              (rel_reg),
        .opn              (opn_reg),
        .debounce_ticks   (debounce_ticks_reg),
        .release_ticks    (release_ticks_reg),
        .open_limit_ticks (open_limit_ticks_reg),
        .sensor_level     (s_tdata[0]),
        .open_request     (s_tdata[1]),
        .ctl_next         (ctl_next),
        .dbe_next         (dbe_next),
        .rel_next         (rel_next),
        .opn_next         (opn_next),
        .res              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase  <= PH_LOCKED;
            ctl_reg.magnet <= 1'b1;
            ctl_reg.level  <= 1'b0;
            dbe_reg        <= '0;
            rel_reg        <= '0;
            opn_reg        <= '0;
        end
        else if (s_fire)
        begin
            ctl_reg <= ctl_next;
            dbe_reg <= dbe_next;
            rel_reg <= rel_next;
            opn_reg <= opn_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg};

    // magnet is released exactly while waiting for the timed release
    a_prepared_released: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.phase == PH_PREPARED) |-> !ctl_reg.magnet)
        else $error("magnet energized in prepared phase");

    a_close_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.door_event == EV_CLOSE)
        |-> (res_reg.door_phase == PC_LOCKED && res_reg.magnet_drive))
        else $error("close event without locked result");

    a_alert_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.alert)
        |-> (res_reg.door_phase == PC_OPENED || res_reg.door_phase == PC_TIMEDOUT))
        else $error("alert outside opened or timed-out phase");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |=> $stable(ctl_reg))
        else $error("state changed without a request");

endmodule

// File: design/dls_step.sv
// Per-tick next-state and result logic of the door lock sequencer.
// Purely combinational; depends on dls_pkg.
module dls_step
    import dls_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  ctl_t                   ctl,
    input  logic [TIMER_WIDTH-1:0] dbe,
    input  logic [TIMER_WIDTH-1:0] rel,
    input  logic [TIMER_WIDTH-1:0] opn,
    input  logic [CFG_W-1:0]       debounce_ticks,
    input  logic [CFG_W-1:0]       release_ticks,
    input  logic [CFG_W-1:0]       open_limit_ticks,
    input  logic                   sensor_level,
    input  logic                   open_request,
    output ctl_t                   ctl_next,
    output logic [TIMER_WIDTH-1:0] dbe_next,
    output logic [TIMER_WIDTH-1:0] rel_next,
    output logic [TIMER_WIDTH-1:0] opn_next,
    output res_t                   res
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    logic [TIMER_WIDTH-1:0] dbe_inc;
    logic [TIMER_WIDTH-1:0] rel_inc;
    logic [TIMER_WIDTH-1:0] opn_inc;
    logic                   deb_change;
    logic                   deb_open;
    logic                   rel_done;
    logic                   opn_over;
    logic [1:0]             ev;
    logic                   alert;

    // saturating advance
    assign dbe_inc = (&dbe) ? dbe : dbe + 1'b1;
    assign rel_inc = (&rel) ? rel : rel + 1'b1;
    assign opn_inc = (&opn) ? opn : opn + 1'b1;

    assign deb_change = (CMP_W'(dbe_inc) > CMP_W'(debounce_ticks))
                        && (sensor_level != ctl.level);
    assign deb_open   = deb_change ? sensor_level : ctl.level;
    assign opn_over   = CMP_W'(opn_inc) > CMP_W'(open_limit_ticks);
    // a request outside the locked phase is ignored
    assign rel_done   = CMP_W'(rel_inc) > CMP_W'(release_ticks);

    always_comb
    begin
        ctl_next = ctl;
        dbe_next = dbe_inc;
        rel_next = rel_inc;
        opn_next = opn_inc;
        ev       = EV_NONE;
        alert    = 1'b0;
        unique case (ctl.phase)
            PH_LOCKED:
            begin
                if (open_request)
                begin
                    ctl_next.magnet = 1'b0;
                    ctl_next.phase  = PH_PREPARED;
                    rel_next        = '0;
                end
                else
                begin
                    if (deb_change)
                    begin
                        dbe_next       = '0;
                        ctl_next.level = sensor_level;
                    end
                    if (deb_open)
                    begin
                        ctl_next.phase = PH_OPENED;
                        ev             = EV_OPEN;
                        alert          = 1'b1;
                    end
                end
            end
            PH_PREPARED:
            begin
                if (rel_done)
                begin
                    ctl_next.magnet = 1'b1;
                    ctl_next.phase  = PH_OPENED;
                    opn_next        = '0;
                    ev              = EV_OPEN;
                end
            end
            PH_OPENED, PH_TIMEDOUT:
            begin
                if (deb_change)
                begin
                    dbe_next       = '0;
                    ctl_next.level = sensor_level;
                end
                if (!deb_open)
                begin
                    ctl_next.magnet = 1'b1;
                    ctl_next.phase  = PH_LOCKED;
                    ev              = EV_CLOSE;
                end
                else if (ctl.phase == PH_OPENED && opn_over)
                begin
                    ctl_next.phase = PH_TIMEDOUT;
                    alert          = 1'b1;
                end
            end
            default:
            begin
                ctl_next.phase = PH_LOCKED;
            end
        endcase
        // when a request releases the lock in the locked phase the prepared rules do not run
        // on the same tick; they apply from a later tick, with the release timer cleared
    end

    assign res.magnet_drive = ctl_next.magnet;
    assign res.door_phase   = phase_code(ctl_next.phase);
    assign res.door_event   = ev;
    assign res.alert        = alert;

endmodule
